// ===== src/lottery_scheduler_pick_top_defines.svh =====
// Assertion macros shared by the checker of the lottery pick block.
`ifndef LOTTERY_SCHEDULER_PICK_TOP_DEFINES_SVH
`define LOTTERY_SCHEDULER_PICK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lsp_pkg.sv =====
// Shared constants, operation codes and inter-module types of the lottery pick block.
package lsp_pkg;

    localparam int SLOT_COUNT_DEF  = 64;
    localparam int TICKET_BITS_DEF = 16;

    localparam int OP_W        = 2;
    localparam int SLOT_PORT_W = 6;
    localparam int VALUE_W     = 16;
    localparam int RAND_W      = 31;
    localparam int WIN_W       = 22;

    localparam logic [OP_W-1:0] OP_SET_TICKETS  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_RUNNABLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW         = 2'd2;

    // Write strobes broadcast to every cell.
    typedef struct packed {
        logic set_tickets;
        logic set_runnable;
        logic runnable;
    } lsp_wr_t;

    // Control part of the word that walks along the row of cells.
    typedef struct packed {
        logic token;
        logic hit;
    } lsp_walk_t;

endpackage

// ===== src/lsp_cell.sv =====
// One slot of the lottery table: ticket count, runnable flag and one walk stage.
module lsp_cell
    import lsp_pkg::*;
#(
    parameter int SLOT_W      = 6,
    parameter int TICKET_BITS = TICKET_BITS_DEF,
    parameter int SUM_W       = 22,
    parameter int INDEX       = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lsp_wr_t                wr,
    input  logic [SLOT_PORT_W-1:0] wr_slot,
    input  logic [TICKET_BITS-1:0] wr_tickets,
    output logic [TICKET_BITS-1:0] old_tickets,
    input  logic [SUM_W-1:0]       winning,
    input  lsp_walk_t              walk_in,
    input  logic [SUM_W-1:0]       sum_in,
    input  logic [SLOT_W-1:0]      idx_in,
    output lsp_walk_t              walk_out,
    output logic [SUM_W-1:0]       sum_out,
    output logic [SLOT_W-1:0]      idx_out
);

    localparam int CMP_W = SLOT_PORT_W + SLOT_W;

    logic [TICKET_BITS-1:0] ticket_reg, ticket_next;
    logic                   runnable_reg, runnable_next;
    lsp_walk_t              walk_reg, walk_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;

    logic             match;
    logic             take;
    logic             reach;
    logic [SUM_W-1:0] sum_add;

    assign match       = (CMP_W'(wr_slot) == CMP_W'(INDEX));
    assign old_tickets = match ? ticket_reg : '0;

    assign sum_add = sum_in + SUM_W'(ticket_reg);
    assign take    = walk_in.token && !walk_in.hit && runnable_reg;
    assign reach   = (sum_add >= winning);

    always_comb begin
        ticket_next   = ticket_reg;
        runnable_next = runnable_reg;
        if (wr.set_tickets && match) begin
            ticket_next = wr_tickets;
        end
        if (wr.set_runnable && match) begin
            runnable_next = wr.runnable;
        end

        walk_next.token = walk_in.token;
        walk_next.hit   = walk_in.hit || (take && reach);
        sum_next        = take ? sum_add : sum_in;
        idx_next        = (take && reach) ? SLOT_W'(INDEX) : idx_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticket_reg   <= '0;
            runnable_reg <= 1'b0;
            walk_reg     <= '0;
        end else begin
            ticket_reg   <= ticket_next;
            runnable_reg <= runnable_next;
            walk_reg     <= walk_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        idx_reg <= idx_next;
    end

    assign walk_out = walk_reg;
    assign sum_out  = sum_reg;
    assign idx_out  = idx_reg;

endmodule

// ===== src/lsp_mod.sv =====
// Restoring remainder unit: random value mod (total + 1), one dividend bit per cycle.
module lsp_mod
    import lsp_pkg::*;
#(
    parameter int SUM_W = 22
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAND_W-1:0] dividend,
    input  logic [SUM_W-1:0]  total,
    output logic              done,
    output logic [SUM_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(RAND_W + 1);

    logic [SUM_W:0]    rem_reg, rem_next;
    logic [SUM_W:0]    div_reg, div_next;
    logic [RAND_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [SUM_W+1:0]  shifted;
    logic [SUM_W+1:0]  trial;

    assign shifted = {rem_reg, dvd_reg[RAND_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            div_next  = {1'b0, total} + (SUM_W + 1)'(1);
            dvd_next  = dividend;
            cnt_next  = CNT_W'(RAND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so it fits SUM_W+1 bits.
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = trial[SUM_W:0];
            end else begin
                rem_next = shifted[SUM_W:0];
            end
            dvd_next = {dvd_reg[RAND_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[SUM_W-1:0];

endmodule

// ===== src/lottery_scheduler_pick_top.sv =====
// Lottery pick block: slot table held in a row of cells, remainder unit and control.
//
//   channel   direction  ports
//   s_        in         s_valid s_ready s_op s_slot s_value s_random_value
//   m_        out        m_valid m_ready m_found m_winner_slot m_winning_ticket
//
// One word is worked on at a time. A set word passes the set and output states before
// it reaches the result register. A draw passes the remainder unit (one dividend bit per
// cycle), then the token passes the row of SLOT_COUNT cells, and the walk and output
// states hand the result over. Reset is synchronous and clears the whole table at once.
// A new word is taken while an earlier result still waits for m_ready; a stalled
// result only holds the block once the next result is ready to be written.
module lottery_scheduler_pick_top
    import lsp_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_op,
    input  logic [SLOT_PORT_W-1:0] s_slot,
    input  logic [VALUE_W-1:0]     s_value,
    input  logic [RAND_W-1:0]      s_random_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [SLOT_PORT_W-1:0] m_winner_slot,
    output logic [WIN_W-1:0]       m_winning_ticket
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int SUM_W  = TICKET_BITS + SLOT_W;
    localparam int CMP_W  = SLOT_PORT_W + SLOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_MOD,
        ST_WALK,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [OP_W-1:0]        op_reg;
    logic [SLOT_PORT_W-1:0] slot_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [SUM_W-1:0]       total_reg;
    logic [SUM_W-1:0]       winning_reg;
    logic                   launch_reg;
    logic                   res_found_reg;
    logic [SLOT_W-1:0]      res_idx_reg;
    logic                   m_valid_reg;
    logic                   m_found_reg;
    logic [SLOT_PORT_W-1:0] m_winner_slot_reg;
    logic [WIN_W-1:0]       m_winning_ticket_reg;

    logic                   accept;
    logic                   in_range;
    lsp_wr_t                wr;
    logic [VALUE_W+TICKET_BITS-1:0] value_ext;
    logic [TICKET_BITS-1:0] new_tickets;
    logic [TICKET_BITS-1:0] old_any;
    logic [SUM_W-1:0]       total_next;
    logic                   mod_done;
    logic [SUM_W-1:0]       mod_rem;
    logic [SLOT_W+SLOT_PORT_W-1:0] idx_ext;
    logic [SUM_W+WIN_W-1:0] win_ext;

    lsp_walk_t              walk     [SLOT_COUNT+1];
    logic [SUM_W-1:0]       walk_sum [SLOT_COUNT+1];
    logic [SLOT_W-1:0]      walk_idx [SLOT_COUNT+1];
    logic [TICKET_BITS-1:0] old_tk   [SLOT_COUNT];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign in_range    = (CMP_W'(slot_reg) < CMP_W'(SLOT_COUNT));
    assign value_ext   = {{TICKET_BITS{1'b0}}, value_reg};
    assign new_tickets = value_ext[TICKET_BITS-1:0];

    assign wr.set_tickets  = (state_reg == ST_SET) && (op_reg == OP_SET_TICKETS) && in_range;
    assign wr.set_runnable = (state_reg == ST_SET) && (op_reg == OP_SET_RUNNABLE) && in_range;
    assign wr.runnable     = value_reg[0];

    // Only the addressed cell drives its old count, the others give zero.
    always_comb begin
        old_any = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            old_any = old_any | old_tk[i];
        end
    end

    assign total_next = total_reg - SUM_W'(old_any) + SUM_W'(new_tickets);

    assign walk[0]     = '{token: launch_reg, hit: 1'b0};
    assign walk_sum[0] = '0;
    assign walk_idx[0] = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        lsp_cell #(
            .SLOT_W      (SLOT_W),
            .TICKET_BITS (TICKET_BITS),
            .SUM_W       (SUM_W),
            .INDEX       (g)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .wr          (wr),
            .wr_slot     (slot_reg),
            .wr_tickets  (new_tickets),
            .old_tickets (old_tk[g]),
            .winning     (winning_reg),
            .walk_in     (walk[g]),
            .sum_in      (walk_sum[g]),
            .idx_in      (walk_idx[g]),
            .walk_out    (walk[g+1]),
            .sum_out     (walk_sum[g+1]),
            .idx_out     (walk_idx[g+1])
        );
    end

    lsp_mod #(
        .SUM_W (SUM_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && (s_op == OP_DRAW)),
        .dividend  (s_random_value),
        .total     (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign idx_ext = {{SLOT_PORT_W{1'b0}}, res_idx_reg};
    assign win_ext = {{WIN_W{1'b0}}, winning_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            op_reg               <= '0;
            slot_reg             <= '0;
            value_reg            <= '0;
            total_reg            <= '0;
            winning_reg          <= '0;
            launch_reg           <= 1'b0;
            res_found_reg        <= 1'b0;
            res_idx_reg          <= '0;
            m_valid_reg          <= 1'b0;
            m_found_reg          <= 1'b0;
            m_winner_slot_reg    <= '0;
            m_winning_ticket_reg <= '0;
        end else begin
            launch_reg <= (state_reg == ST_MOD) && mod_done;
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_op;
                        slot_reg  <= s_slot;
                        value_reg <= s_value;
                        state_reg <= (s_op == OP_DRAW) ? ST_MOD : ST_SET;
                    end
                end
                ST_SET: begin
                    if (wr.set_tickets) begin
                        total_reg <= total_next;
                    end
                    winning_reg   <= '0;
                    res_found_reg <= 1'b0;
                    res_idx_reg   <= '0;
                    state_reg     <= ST_OUT;
                end
                ST_MOD: begin
                    if (mod_done) begin
                        winning_reg <= mod_rem;
                        state_reg   <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (walk[SLOT_COUNT].token) begin
                        res_found_reg <= walk[SLOT_COUNT].hit;
                        res_idx_reg   <= walk[SLOT_COUNT].hit ? walk_idx[SLOT_COUNT] : '0;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_found_reg          <= res_found_reg;
                        m_winner_slot_reg    <= idx_ext[SLOT_PORT_W-1:0];
                        m_winning_ticket_reg <= win_ext[WIN_W-1:0];
                        state_reg            <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = m_found_reg;
    assign m_winner_slot    = m_winner_slot_reg;
    assign m_winning_ticket = m_winning_ticket_reg;

endmodule

// ===== src/lsp_checker.sv =====
// Port-level checker for the lottery pick block, bound to its top level.
`include "lottery_scheduler_pick_top_defines.svh"

module lsp_checker
    import lsp_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_found,
    input logic [SLOT_PORT_W-1:0] m_winner_slot,
    input logic [WIN_W-1:0]       m_winning_ticket
);

    // A stalled result word keeps its contents.
    `LSP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_winner_slot) && $stable(m_winning_ticket) && $stable(m_found), "result word changed while stalled")

    // A result without a winner reports slot zero.
    `LSP_ASSERT_SAME(a_no_win_slot, m_valid && !m_found, m_winner_slot == '0, "winner slot not zero without a winner")

    // The block works on one word at a time.
    `LSP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "input taken again straight after acceptance")

    // A new result only appears while a word is being worked on.
    `LSP_ASSERT_SAME(a_result_from_work, $rose(m_valid), !$past(s_ready), "result appeared while the block was idle")

endmodule

bind lottery_scheduler_pick_top lsp_checker u_lsp_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the lottery pick block: slot table predictor, scoreboard and drivers.

class pick_ledger;
    typedef struct packed {
        bit        found;
        bit [5:0]  slot;
        bit [21:0] ticket;
    } pick_t;

    localparam int        SLOTS       = lsp_pkg::SLOT_COUNT_DEF;
    localparam bit [15:0] TICKET_MASK = 16'((1 << lsp_pkg::TICKET_BITS_DEF) - 1);

    bit [15:0] slot_tickets[SLOTS];
    bit        slot_live[SLOTS];
    bit [21:0] ticket_sum;
    pick_t     expected_picks[$];

    int mismatches;
    int set_ticket_words, set_live_words, spare_op_words, draw_words;
    int draws_won, draws_empty, draws_at_zero;

    function new();
        foreach (slot_tickets[i]) begin
            slot_tickets[i] = '0;
            slot_live[i]    = 1'b0;
        end
        ticket_sum = '0;
    endfunction

    // Updates the table for one accepted word and queues the result it must produce.
    function void note_word(bit [1:0] op, bit [5:0] slot, bit [15:0] value, bit [30:0] rnd);
        pick_t             p;
        bit [15:0]         t;
        longint unsigned   winning;
        longint unsigned   run;
        p   = '0;
        run = 0;
        if (op == lsp_pkg::OP_SET_TICKETS) begin
            set_ticket_words++;
            if (slot < SLOTS) begin
                t = value & TICKET_MASK;
                ticket_sum = ticket_sum - 22'(slot_tickets[slot]) + 22'(t);
                slot_tickets[slot] = t;
            end
        end else if (op == lsp_pkg::OP_SET_RUNNABLE) begin
            set_live_words++;
            if (slot < SLOTS)
                slot_live[slot] = value[0];
        end else if (op == lsp_pkg::OP_DRAW) begin
            draw_words++;
            winning  = 64'(rnd) % (64'(ticket_sum) + 64'd1);
            p.ticket = winning[21:0];
            if (winning == 0)
                draws_at_zero++;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_live[i]) begin
                    run += 64'(slot_tickets[i]);
                    if (run >= winning) begin
                        p.found = 1'b1;
                        p.slot  = 6'(i);
                        break;
                    end
                end
            end
            if (p.found)
                draws_won++;
            else
                draws_empty++;
        end else begin
            spare_op_words++;
        end
        expected_picks.push_back(p);
    endfunction

    function void check_pick(bit found, bit [5:0] slot, bit [21:0] ticket);
        pick_t p;
        if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: found=%0d slot=%0d ticket=%0d",
                         found, slot, ticket);
        end else begin
            p = expected_picks.pop_front();
            if (p.found !== found || p.slot !== slot || p.ticket !== ticket) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pick mismatch: expected found=%0d slot=%0d ticket=%0d, got found=%0d slot=%0d ticket=%0d",
                             p.found, p.slot, p.ticket, found, slot, ticket);
            end
        end
    endfunction

    function int pending();
        return expected_picks.size();
    endfunction
endclass

module testbench;
    import lsp_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;
    localparam int              IDLE_LIMIT = 2000;
    localparam int              HOLD_LEN   = 400;
    localparam int              RANDOM_WORDS = 950;

    logic                   aclk;
    logic                   aresetn          = 1'b0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_op             = '0;
    logic [SLOT_PORT_W-1:0] s_slot           = '0;
    logic [VALUE_W-1:0]     s_value          = '0;
    logic [RAND_W-1:0]      s_random_value   = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic                   m_found;
    logic [SLOT_PORT_W-1:0] m_winner_slot;
    logic [WIN_W-1:0]       m_winning_ticket;

    pick_ledger ledger = new();
    bit         steady = 1'b0;
    int         idle_cycles = 0;

    lottery_scheduler_pick_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_slot           (s_slot),
        .s_value          (s_value),
        .s_random_value   (s_random_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_winner_slot    (m_winner_slot),
        .m_winning_ticket (m_winning_ticket)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    // Offers one word after a random gap and returns once it has been taken.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [SLOT_PORT_W-1:0] slot,
                             input logic [VALUE_W-1:0] value, input logic [RAND_W-1:0] rnd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_slot         <= slot;
        s_value        <= value;
        s_random_value <= rnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_word(op, slot, value, rnd);
    endtask

    // Result side: random stalls, plus one long hold-off that backs the block up.
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (taken == 500)
                stall = HOLD_LEN;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            ledger.check_pick(m_found, m_winner_slot, m_winning_ticket);
            taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no word moved for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int                     r;
        logic [OP_W-1:0]        op;
        logic [SLOT_PORT_W-1:0] slot;
        logic [VALUE_W-1:0]     value;
        logic [RAND_W-1:0]      rnd;
        logic [31:0]            span;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty table, a zero-count winner, missing draws and table extremes.
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd0);
        send_word(OP_DRAW,         6'd63, 16'hFFFF, 31'h7FFF_FFFF);
        send_word(OP_SET_RUNNABLE, 6'd0,  16'h0001, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd12345);
        send_word(OP_SET_TICKETS,  6'd63, 16'hFFFF, 31'd0);
        send_word(OP_SET_TICKETS,  6'd5,  16'h0001, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd65536);
        send_word(OP_SET_RUNNABLE, 6'd63, 16'hFFFF, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'h7FFF_FFFF);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd65536);
        send_word(OP_SET_RUNNABLE, 6'd5,  16'hFFFE, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd1);
        send_word(OP_SET_RUNNABLE, 6'd5,  16'h0001, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd1);
        send_word(OP_SPARE,        6'd63, 16'hFFFF, 31'h7FFF_FFFF);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd65536);
        send_word(OP_SET_TICKETS,  6'd63, 16'h0000, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd2);
        send_word(OP_SET_TICKETS,  6'd0,  16'hFFFF, 31'd0);
        send_word(OP_SET_RUNNABLE, 6'd0,  16'h0000, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'h7FFF_FFFF);
        send_word(OP_SET_RUNNABLE, 6'd0,  16'h0001, 31'd0);
        send_word(OP_DRAW,         6'd0,  16'h0000, 31'd65535);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 300 && n < 420);
            r     = $urandom_range(0, 99);
            slot  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
            value = 16'($urandom);
            rnd   = 31'($urandom);
            if (r < 30) begin
                op = OP_SET_TICKETS;
                case ($urandom_range(0, 9))
                    0, 1:    value = 16'h0000;
                    2:       value = 16'hFFFF;
                    3, 4, 5: value = 16'($urandom_range(0, 15));
                    default: ;
                endcase
            end else if (r < 50) begin
                op       = OP_SET_RUNNABLE;
                value[0] = ($urandom_range(0, 9) < 7);
            end else if (r < 95) begin
                op   = OP_DRAW;
                span = 32'(ledger.ticket_sum) + 32'd1;
                // Aim the drawn ticket at the interesting ends as well as at random.
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:      rnd = 31'(ledger.ticket_sum);
                    4, 5, 6:         rnd = 31'(span * 32'($urandom_range(0, 400)));
                    7, 8, 9, 10, 11: rnd = 31'($urandom_range(0, ledger.ticket_sum));
                    default:         ;
                endcase
            end else begin
                op = OP_SPARE;
            end
            send_word(op, slot, value, rnd);
        end
        s_valid <= 1'b0;

        while (ledger.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d ticket writes, %0d runnable writes, %0d unused-op words and %0d draws.",
                 ledger.set_ticket_words, ledger.set_live_words, ledger.spare_op_words,
                 ledger.draw_words);
        $display("Draws: %0d picked a slot, %0d found none, %0d drew ticket zero; %0d mismatches.",
                 ledger.draws_won, ledger.draws_empty, ledger.draws_at_zero, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
